@@ src/msort_pkg.sv @@
// Shared types and constants of the merge sorter.
`timescale 1ns / 1ps
`default_nettype none

package msort_pkg;

    localparam int VALUE_W = 32;
    localparam int MAX_ITEMS_DEF = 64;

    typedef logic signed [VALUE_W-1:0] t_value;

    typedef struct packed {
        t_value value;
        logic   valid;
        logic   move;
    } t_cell_link;

    typedef struct packed {
        logic load;
        logic unload;
    } t_cell_ctrl;

    // The head of the row sees a full neighbor that never moves, so the first
    // cell at or past the insertion point takes the new value.
    localparam t_cell_link LINK_HEAD = '{value: '0, valid: 1'b1, move: 1'b0};
    // The tail of the row sees an empty neighbor, which shifts in on unload.
    localparam t_cell_link LINK_TAIL = '{value: '0, valid: 1'b0, move: 1'b0};

endpackage

`default_nettype wire

@@ src/msort_in_if.sv @@
// Input channel of the merge sorter: one list element per transfer.
`timescale 1ns / 1ps
`default_nettype none

interface msort_in_if;
    logic                  valid;
    logic                  ready;
    msort_pkg::t_value     in_value;
    logic                  in_last;

    modport source(output valid, output in_value, output in_last, input ready);
    modport sink(input valid, input in_value, input in_last, output ready);
endinterface

`default_nettype wire

@@ src/msort_out_if.sv @@
// Output channel of the merge sorter: one sorted element per transfer.
`timescale 1ns / 1ps
`default_nettype none

interface msort_out_if;
    logic                  valid;
    logic                  ready;
    msort_pkg::t_value     out_value;
    logic                  out_last;
    logic                  overflow;

    modport source(output valid, output out_value, output out_last, output overflow,
                   input ready);
    modport sink(input valid, input out_value, input out_last, input overflow,
                 output ready);
endinterface

`default_nettype wire

@@ src/msort_cell.sv @@
// One cell of the sorting row: holds one element and trades with its neighbors.
`timescale 1ns / 1ps
`default_nettype none

module msort_cell (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  msort_pkg::t_cell_ctrl   i_ctrl,
    input  msort_pkg::t_value       i_x,
    input  msort_pkg::t_cell_link   i_left,
    input  msort_pkg::t_cell_link   i_right,
    output msort_pkg::t_cell_link   o_link
);

    msort_pkg::t_value r_value;
    logic              r_valid;
    logic              w_move;

    // A cell is at or past the insertion point when it is empty or holds a
    // strictly larger value, so equal values keep their arrival order.
    assign w_move = !r_valid || (r_value > i_x);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.unload) begin
            r_valid <= i_right.valid;
        end else if (i_ctrl.load && w_move) begin
            r_valid <= r_valid || i_left.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.unload) begin
            r_value <= i_right.value;
        end else if (i_ctrl.load && w_move) begin
            r_value <= i_left.move ? i_left.value : i_x;
        end
    end

    assign o_link = '{value: r_value, valid: r_valid, move: w_move};

endmodule

`default_nettype wire

@@ src/merge_sorter_core.sv @@
// Top level of the merge sorter: a row of sorting cells and the batch control.
//
//   channel  modport  direction  payload                        transfer when
//   i_in     sink     in         in_value, in_last              valid && ready
//   o_out    source   out        out_value, out_last, overflow  valid && ready
//
// Each element that finds room is inserted into the sorted row in the cycle of its
// transfer; one beyond capacity is dropped and sets overflow. After the last element
// the batch drains from the head cell, one result per cycle while o_out is ready.
// i_in.ready is low while a batch drains; a stall on o_out holds the row.
// Reset empties the row at once; there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module merge_sorter_core #(
    parameter int MAX_ITEMS = msort_pkg::MAX_ITEMS_DEF
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    msort_in_if.sink         i_in,
    msort_out_if.source      o_out
);

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    typedef enum logic {
        ST_LOAD,
        ST_DRAIN
    } t_state;

    t_state                 r_state;
    logic [CNT_W-1:0]       r_count;
    logic                   r_dropped;

    logic                   w_in_fire;
    logic                   w_out_fire;
    logic                   w_room;
    msort_pkg::t_cell_ctrl  w_ctrl;
    msort_pkg::t_cell_link  w_link [MAX_ITEMS];

    assign w_in_fire  = i_in.valid && i_in.ready;
    assign w_out_fire = o_out.valid && o_out.ready;
    assign w_room     = r_count < CNT_W'(MAX_ITEMS);

    assign w_ctrl = '{load: w_in_fire && w_room, unload: w_out_fire};

    for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
        msort_pkg::t_cell_link w_left;
        msort_pkg::t_cell_link w_right;

        if (g == 0) begin : g_head
            assign w_left = msort_pkg::LINK_HEAD;
        end else begin : g_body
            assign w_left = w_link[g-1];
        end

        if (g == MAX_ITEMS - 1) begin : g_tail
            assign w_right = msort_pkg::LINK_TAIL;
        end else begin : g_next
            assign w_right = w_link[g+1];
        end

        msort_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_ctrl),
            .i_x     (i_in.in_value),
            .i_left  (w_left),
            .i_right (w_right),
            .o_link  (w_link[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_LOAD;
            r_count   <= '0;
            r_dropped <= 1'b0;
        end else begin
            case (r_state)
                ST_LOAD: begin
                    if (w_in_fire) begin
                        if (w_room) begin
                            r_count <= r_count + CNT_W'(1);
                        end else begin
                            r_dropped <= 1'b1;
                        end
                        if (i_in.in_last) begin
                            r_state <= ST_DRAIN;
                        end
                    end
                end
                ST_DRAIN: begin
                    if (w_out_fire && o_out.out_last) begin
                        r_state   <= ST_LOAD;
                        r_count   <= '0;
                        r_dropped <= 1'b0;
                    end
                end
                default: begin
                    r_state <= ST_LOAD;
                end
            endcase
        end
    end

    assign i_in.ready      = (r_state == ST_LOAD);
    assign o_out.valid     = (r_state == ST_DRAIN) && w_link[0].valid;
    assign o_out.out_value = w_link[0].value;
    assign o_out.out_last  = !w_link[1].valid;
    assign o_out.overflow  = r_dropped;

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in.ready && o_out.valid))
        else $error("input accepted while results are pending");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_ITEMS))
        else $error("element count beyond capacity");

    a_drain_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN) |-> o_out.valid)
        else $error("draining with an empty head cell");

    a_back_to_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_fire && o_out.out_last) |=> (i_in.ready && !w_link[0].valid))
        else $error("row not empty after the final result");

    a_load_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && w_room) |=> w_link[0].valid)
        else $error("insertion left the head cell empty");

endmodule

`default_nettype wire

@@ dv/tb.sv @@
// Testbench for merge_sorter_core: sends batches and checks results in order.
`timescale 1ns / 1ps

module tb;

    localparam int CAPACITY  = 64;
    localparam int LONG_HOLD = 400;
    localparam int N_ITEMS   = 270;

    typedef struct {
        msort_pkg::t_value value;
        logic              last;
    } t_element;

    typedef struct {
        msort_pkg::t_value value;
        logic              last;
        logic              overflow;
    } t_sorted;

    typedef enum int {STALL_NONE, STALL_RANDOM, STALL_SPARSE, STALL_MOSTLY} t_stall_mode;

    logic clk;
    logic rst_n;

    msort_in_if  in_ch();
    msort_out_if out_ch();

    merge_sorter_core #(.MAX_ITEMS(CAPACITY)) u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    t_element          pending_q[$];
    t_sorted           sorted_q[$];
    msort_pkg::t_value held_values[$];
    logic              held_dropped = 1'b0;

    int errors           = 0;
    int items_queued     = 0;
    int items_taken      = 0;
    int batches_done     = 0;
    int overflow_batches = 0;
    int results_checked  = 0;

    int burst_left = 1;
    int gap_left   = 0;

    logic        hold_armed = 1'b0;
    logic        hold_used  = 1'b0;
    int          hold_left  = 0;
    int          mode_left  = 0;
    int          cyc_cnt    = 0;
    t_stall_mode stall_mode = STALL_NONE;

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        errors++;
    endtask

    // Keeps the held batch in ascending order; an equal value goes after its peers.
    task automatic absorb_element(input msort_pkg::t_value value, input logic last);
        int pos;
        int n;
        if (held_values.size() < CAPACITY) begin
            pos = held_values.size();
            for (int i = 0; i < held_values.size(); i++) begin
                if (held_values[i] > value) begin
                    pos = i;
                    break;
                end
            end
            held_values.insert(pos, value);
        end else begin
            held_dropped = 1'b1;
        end
        if (last) begin
            n = held_values.size();
            for (int k = 0; k < n; k++) begin
                sorted_q.push_back('{value: held_values[k], last: (k == n - 1),
                                     overflow: held_dropped});
            end
            batches_done++;
            if (held_dropped) overflow_batches++;
            held_values.delete();
            held_dropped = 1'b0;
        end
    endtask

    function automatic msort_pkg::t_value rand_value();
        int          pick;
        int unsigned offset;
        pick   = $urandom_range(0, 9);
        offset = $urandom_range(0, 15);
        case (pick)
            5, 6: return msort_pkg::t_value'($signed($urandom_range(0, 16)) - 8);
            7: return 32'sh7fff_ffff;
            8: return 32'sh8000_0000;
            9: begin
                if ($urandom_range(0, 1) != 0) begin
                    return msort_pkg::t_value'(32'sh7fff_fff0 + offset);
                end
                return msort_pkg::t_value'(32'sh8000_0000 + offset);
            end
            default: return msort_pkg::t_value'($urandom);
        endcase
    endfunction

    task automatic queue_element(input msort_pkg::t_value value, input logic last);
        pending_q.push_back('{value: value, last: last});
        items_queued++;
    endtask

    task automatic queue_batch(input int n);
        for (int i = 0; i < n; i++) begin
            queue_element(rand_value(), i == n - 1);
        end
    endtask

    task automatic queue_small_batch();
        if ($urandom_range(0, 4) == 0) queue_batch(2);
        else queue_batch($urandom_range(1, 12));
    endtask

    always @(posedge clk) begin
        logic took;
        logic offer;
        took = in_ch.valid && in_ch.ready;
        offer = 1'b0;
        if (!rst_n) begin
            in_ch.valid    <= 1'b0;
            in_ch.in_value <= '0;
            in_ch.in_last  <= 1'b0;
        end else begin
            if (took) begin
                absorb_element(pending_q[0].value, pending_q[0].last);
                void'(pending_q.pop_front());
                items_taken++;
            end
            if (in_ch.valid && !took) begin
                offer = 1'b1;
            end else if (gap_left > 0) begin
                gap_left--;
            end else if (pending_q.size() != 0) begin
                offer = 1'b1;
                if (burst_left <= 1) begin
                    burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                                             : $urandom_range(1, 20);
                    gap_left = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 40)
                                                           : $urandom_range(0, 5);
                end else begin
                    burst_left--;
                end
            end
            in_ch.valid <= offer;
            if (offer) begin
                in_ch.in_value <= pending_q[0].value;
                in_ch.in_last  <= pending_q[0].last;
            end
        end
    end

    always @(posedge clk) begin
        t_sorted want;
        logic rdy;
        rdy = 1'b1;
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (sorted_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result value %0d",
                                              out_ch.out_value));
                end else begin
                    want = sorted_q.pop_front();
                    if (out_ch.out_value !== want.value)
                        report_mismatch($sformatf("result %0d out_value %0d, expected %0d",
                                                  results_checked, out_ch.out_value, want.value));
                    if (out_ch.out_last !== want.last)
                        report_mismatch($sformatf("result %0d out_last %b, expected %b",
                                                  results_checked, out_ch.out_last, want.last));
                    if (out_ch.overflow !== want.overflow)
                        report_mismatch($sformatf("result %0d overflow %b, expected %b",
                                                  results_checked, out_ch.overflow,
                                                  want.overflow));
                end
                results_checked++;
            end
            cyc_cnt++;
            if (mode_left == 0) begin
                stall_mode = t_stall_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 80);
            end else begin
                mode_left--;
            end
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else if (hold_armed && !hold_used && out_ch.valid) begin
                hold_used = 1'b1;
                hold_left = LONG_HOLD;
                rdy = 1'b0;
            end else begin
                case (stall_mode)
                    STALL_NONE:   rdy = 1'b1;
                    STALL_RANDOM: rdy = ($urandom_range(0, 1) != 0);
                    STALL_SPARSE: rdy = ((cyc_cnt % 4) == 0);
                    STALL_MOSTLY: rdy = ((cyc_cnt % 8) != 0);
                    default:      rdy = 1'b1;
                endcase
            end
            out_ch.ready <= rdy;
        end
    end

    initial begin
        in_ch.valid    = 1'b0;
        in_ch.in_value = '0;
        in_ch.in_last  = 1'b0;
        out_ch.ready   = 1'b0;
        rst_n          = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Single-element batches at the extremes.
        queue_element(32'sh8000_0000, 1'b1);
        queue_element(32'sh7fff_ffff, 1'b1);
        queue_element(32'sd0, 1'b1);
        queue_element(-32'sd1, 1'b1);
        // Mixed extremes with duplicates.
        queue_element(32'sh7fff_ffff, 1'b0);
        queue_element(32'sh8000_0000, 1'b0);
        queue_element(32'sd0, 1'b0);
        queue_element(-32'sd1, 1'b0);
        queue_element(32'sd1, 1'b0);
        queue_element(32'sd5, 1'b0);
        queue_element(32'sd5, 1'b0);
        queue_element(-32'sd5, 1'b0);
        queue_element(32'sh8000_0000, 1'b0);
        queue_element(32'sh7fff_ffff, 1'b1);
        // Already ascending.
        for (int i = -3; i <= 2; i++) queue_element(msort_pkg::t_value'(i), i == 2);
        // All equal.
        for (int i = 0; i < 4; i++) queue_element(32'sd7, i == 3);

        // The sender stays quiet until every result of the directed part is back.
        while (pending_q.size() != 0 || sorted_q.size() != 0) @(posedge clk);

        // The first full batch meets a long receiver hold-off while more items are offered.
        hold_armed = 1'b1;
        queue_batch(CAPACITY);
        while (items_queued < 130) queue_small_batch();
        queue_batch(CAPACITY + 1);
        queue_small_batch();
        queue_batch(CAPACITY + 1 + $urandom_range(1, 4));
        while (items_queued < N_ITEMS) queue_small_batch();

        while (pending_q.size() != 0 || in_ch.valid) @(posedge clk);
        while (sorted_q.size() != 0) @(posedge clk);
        repeat (CAPACITY + 10) @(posedge clk);

        if (sorted_q.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived", sorted_q.size()));

        $display("Sorted %0d elements in %0d batches, %0d of them over capacity.",
                 items_taken, batches_done, overflow_batches);
        $display("Checked %0d results across extremes, duplicates and a %0d-cycle hold-off.",
                 results_checked, LONG_HOLD);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #500us;
        $display("Timeout with %0d results outstanding.", sorted_q.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule
